// ===== src/bsdo_pkg.sv =====
// ----------------------------------------------------------------------------
// bsdo_pkg: shared types and constants of the bounded drop-oldest stack
// command codes, word formats, cell operations and register map
// ----------------------------------------------------------------------------
package bsdo_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the channel words
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;
    localparam int CAP_MAX = (2 ** CAP_W) - 1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register port
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_SHIFT_DOWN = 2'd1,
        OP_SHIFT_UP   = 2'd2
    } cell_op_t;

    typedef struct packed {
        cmd_t               command;
        logic [VALUE_W-1:0] push_value;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] top_value;
        logic [CAP_W-1:0]   entry_count;
        logic               is_empty;
        logic               is_full;
        logic               underflow;
        logic               oldest_dropped;
    } out_word_t;

endpackage

// ===== src/bsdo_cell.sv =====
// ----------------------------------------------------------------------------
// bsdo_cell: one storage cell of the shifting stack
// takes the word above on push, the word below on pop, holds otherwise
// ----------------------------------------------------------------------------
module bsdo_cell #(
    parameter int DATA_WIDTH = bsdo_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  bsdo_pkg::cell_op_t    op,
    input  logic [DATA_WIDTH-1:0] from_above,
    input  logic [DATA_WIDTH-1:0] from_below,
    output logic [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] q_reg;
    logic [DATA_WIDTH-1:0] q_next;

    always_comb begin
        unique case (op)
            bsdo_pkg::OP_SHIFT_DOWN: q_next = from_above;
            bsdo_pkg::OP_SHIFT_UP:   q_next = from_below;
            default:                 q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== src/bounded_stack_drop_oldest.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_drop_oldest: lifo stack that drops its oldest word when full
// a row of shifting cells, top of stack in cell 0, count and flags in control
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             word
//  s_        in         s_valid / s_ready     command, push_value
//  m_        out        m_valid / m_ready     top_value, count and flags
//  apb       in/out     psel, penable, pwrite capacity register at 0x0
//
// one command per cycle; its result word appears in the output register
// on the cycle after acceptance
// the throughput is set by the output register: s_ready is high whenever
// that register is empty or is being emptied in the same cycle
// aresetn (synchronous, active low) clears the count, the output valid and
// sets capacity to 16; the cells hold no reset and need no clearing pass
// a stalled m_ready holds the result word and stops new commands
// ----------------------------------------------------------------------------
module bounded_stack_drop_oldest #(
    parameter int DEPTH      = bsdo_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsdo_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bsdo_pkg::in_word_t            s_data,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output bsdo_pkg::out_word_t           m_data,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsdo_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsdo_pkg::APB_DW-1:0]   pwdata,
    output logic [bsdo_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // capacity above the cell count is clamped to the cell count
    localparam int DEPTH_LIM = (DEPTH > bsdo_pkg::CAP_MAX) ? bsdo_pkg::CAP_MAX : DEPTH;
    localparam logic [bsdo_pkg::CAP_W-1:0] DEPTH_CAP = DEPTH_LIM[bsdo_pkg::CAP_W-1:0];

    // register port
    logic                        cfg_wr;
    logic [bsdo_pkg::CAP_W-1:0]  cap_reg;
    logic [bsdo_pkg::CAP_W-1:0]  cap_next;
    logic [bsdo_pkg::CAP_W-1:0]  eff_cap;

    // stack control
    logic                        accept;
    logic [bsdo_pkg::CAP_W-1:0]  count_reg;
    logic [bsdo_pkg::CAP_W-1:0]  count_next;
    bsdo_pkg::cell_op_t          op;
    logic                        is_read;
    logic                        stack_empty;
    logic                        dropped;

    // output register
    logic                        m_valid_reg;
    logic                        m_valid_next;
    bsdo_pkg::out_word_t         m_data_reg;
    bsdo_pkg::out_word_t         m_data_next;

    // cell row
    logic [DATA_WIDTH-1:0]       push_data;
    logic [DATA_WIDTH-1:0]       cell_q [DEPTH];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[bsdo_pkg::ADDR_W-1] == bsdo_pkg::REG_CAPACITY);
    assign prdata = (paddr[bsdo_pkg::ADDR_W-1] == bsdo_pkg::REG_CAPACITY)
                    ? bsdo_pkg::APB_DW'(cap_reg) : '0;

    assign cap_next = cfg_wr ? pwdata[bsdo_pkg::CAP_W-1:0] : cap_reg;

    // zero acts as one, anything above the cell count as the cell count
    always_comb begin
        priority if (cap_reg == '0) begin
            eff_cap = bsdo_pkg::CAP_W'(1);
        end else if (cap_reg > DEPTH_CAP) begin
            eff_cap = DEPTH_CAP;
        end else begin
            eff_cap = cap_reg;
        end
    end

    // accept while the output register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign stack_empty = (count_reg == '0);
    assign is_read     = (s_data.command == bsdo_pkg::CMD_POP)
                         || (s_data.command == bsdo_pkg::CMD_PEEK);
    assign push_data   = DATA_WIDTH'(s_data.push_value);

    // next count and cell operation
    always_comb begin
        count_next = count_reg;
        op         = bsdo_pkg::OP_HOLD;
        dropped    = 1'b0;
        if (cfg_wr) begin
            // capacity write empties the stack
            count_next = '0;
        end else if (accept) begin
            unique case (s_data.command)
                bsdo_pkg::CMD_PUSH: begin
                    op = bsdo_pkg::OP_SHIFT_DOWN;
                    if (count_reg >= eff_cap) begin
                        // bottom word falls out of the counted range
                        count_next = eff_cap;
                        dropped    = 1'b1;
                    end else begin
                        count_next = count_reg + bsdo_pkg::CAP_W'(1);
                    end
                end
                bsdo_pkg::CMD_POP: begin
                    if (!stack_empty) begin
                        op         = bsdo_pkg::OP_SHIFT_UP;
                        count_next = count_reg - bsdo_pkg::CAP_W'(1);
                    end
                end
                bsdo_pkg::CMD_PEEK: begin
                    count_next = count_reg;
                end
                bsdo_pkg::CMD_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // result word
    always_comb begin
        m_data_next.top_value      = (is_read && !stack_empty)
                                     ? bsdo_pkg::VALUE_W'(cell_q[0]) : '0;
        m_data_next.entry_count    = count_next;
        m_data_next.is_empty       = (count_next == '0);
        m_data_next.is_full        = (count_next == eff_cap);
        m_data_next.underflow      = is_read && stack_empty;
        m_data_next.oldest_dropped = dropped;
    end

    always_comb begin
        priority if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= bsdo_pkg::CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cap_reg     <= cap_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only with a new word
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // row of cells: cell 0 is the top, push shifts toward the bottom
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] above;
        logic [DATA_WIDTH-1:0] below;

        if (i == 0) begin : g_first
            assign above = push_data;
        end else begin : g_inner_a
            assign above = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign below = cell_q[i];
        end else begin : g_inner_b
            assign below = cell_q[i+1];
        end

        bsdo_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .from_above (above),
            .from_below (below),
            .q          (cell_q[i])
        );
    end

    // count never leaves the effective capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= eff_cap)
        else $error("stack count above capacity");

    // a drop always leaves the stack full
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.oldest_dropped) |-> m_data_reg.is_full)
        else $error("drop reported on a stack that is not full");

    // underflow only on an empty stack with a zero value
    a_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.underflow)
        |-> (m_data_reg.is_empty && (m_data_reg.top_value == '0)))
        else $error("underflow word not empty or with a value");

    // a pop on a non-empty stack removes exactly one word
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_wr && (s_data.command == bsdo_pkg::CMD_POP) && !stack_empty)
        |=> (count_reg == ($past(count_reg) - bsdo_pkg::CAP_W'(1))))
        else $error("pop did not lower the count by one");

endmodule

// ===== tb/tb_bounded_stack_drop_oldest.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_stack_drop_oldest: self-checking bench of the drop-oldest stack
// a shadow stack predicts one result word per command word; random valid and
// ready gaps on both channels, capacity rewritten over the apb port between
// phases, directed corner cases first and then long random command streams
// ----------------------------------------------------------------------------
module tb_bounded_stack_drop_oldest;

    // shadow of the stack: held values bottom first, plus expected results
    class stack_shadow;
        logic [bsdo_pkg::VALUE_W-1:0] shadow_entries[$];
        bsdo_pkg::out_word_t          pending_results[$];
        int unsigned                  cap_eff;
        int unsigned                  errors;

        function new();
            cap_eff = bsdo_pkg::DEPTH_DEF;
            errors  = 0;
        endfunction

        // a capacity write empties the stack; zero acts as one, large as depth
        function void set_capacity(logic [bsdo_pkg::CAP_W-1:0] raw);
            if (raw == 0) begin
                cap_eff = 1;
            end else if (raw > bsdo_pkg::DEPTH_DEF) begin
                cap_eff = bsdo_pkg::DEPTH_DEF;
            end else begin
                cap_eff = 32'(raw);
            end
            shadow_entries.delete();
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_command(bsdo_pkg::in_word_t w);
            bsdo_pkg::out_word_t r;
            r = '0;
            case (w.command)
                bsdo_pkg::CMD_PUSH: begin
                    shadow_entries.push_back(w.push_value);
                    if (shadow_entries.size() > cap_eff) begin
                        void'(shadow_entries.pop_front());
                        r.oldest_dropped = 1'b1;
                    end
                end
                bsdo_pkg::CMD_POP, bsdo_pkg::CMD_PEEK: begin
                    if (shadow_entries.size() == 0) begin
                        r.underflow = 1'b1;
                    end else begin
                        r.top_value = shadow_entries[$];
                        if (w.command == bsdo_pkg::CMD_POP) void'(shadow_entries.pop_back());
                    end
                end
                bsdo_pkg::CMD_CLEAR: begin
                    shadow_entries.delete();
                end
            endcase
            r.entry_count = bsdo_pkg::CAP_W'(shadow_entries.size());
            r.is_empty    = (shadow_entries.size() == 0);
            r.is_full     = (shadow_entries.size() == cap_eff);
            pending_results.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(bsdo_pkg::out_word_t got);
            bsdo_pkg::out_word_t want;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result word %h with none expected", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.top_value !== want.top_value)
                flag_mismatch($sformatf("top_value %h, want %h", got.top_value, want.top_value));
            if (got.entry_count !== want.entry_count)
                flag_mismatch($sformatf("entry_count %0d, want %0d",
                                        got.entry_count, want.entry_count));
            if (got.is_empty !== want.is_empty)
                flag_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
            if (got.is_full !== want.is_full)
                flag_mismatch($sformatf("is_full %b, want %b", got.is_full, want.is_full));
            if (got.underflow !== want.underflow)
                flag_mismatch($sformatf("underflow %b, want %b", got.underflow, want.underflow));
            if (got.oldest_dropped !== want.oldest_dropped)
                flag_mismatch($sformatf("oldest_dropped %b, want %b",
                                        got.oldest_dropped, want.oldest_dropped));
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    bsdo_pkg::in_word_t            s_data;
    logic                          m_valid;
    logic                          m_ready;
    bsdo_pkg::out_word_t           m_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bsdo_pkg::ADDR_W-1:0]   paddr;
    logic [bsdo_pkg::APB_DW-1:0]   pwdata;
    logic [bsdo_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    stack_shadow         shadow;
    bit                  no_idle;

    bounded_stack_drop_oldest i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns clock
    always #10 aclk = ~aclk;

    // mostly short gaps, a few long ones, none during no-idle stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random command word; push share set per chunk so depth rises and falls
    function automatic bsdo_pkg::in_word_t random_word(int unsigned push_pct);
        bsdo_pkg::in_word_t w;
        int unsigned        r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            w.command = bsdo_pkg::CMD_PUSH;
        end else if (r >= 97) begin
            w.command = bsdo_pkg::CMD_CLEAR;
        end else if ($urandom_range(0, 1) == 1) begin
            w.command = bsdo_pkg::CMD_POP;
        end else begin
            w.command = bsdo_pkg::CMD_PEEK;
        end
        case ($urandom_range(0, 9))
            0: w.push_value = '0;
            1: w.push_value = '1;
            default: w.push_value = $urandom;
        endcase
        return w;
    endfunction

    // both handshakes are observed here, on values from before the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) shadow.note_command(s_data);
            if (m_valid && m_ready) shadow.check_result(m_data);
        end
    end

    // maybe idle, then present one command word and hold it until taken
    task automatic send_word(input bsdo_pkg::in_word_t w);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait until every expected result word has come
    task automatic drain_results();
        s_valid <= 1'b0;
        // let the clock edge pass so the last accepted word is already noted
        @(posedge aclk);
        while (shadow.pending() != 0) @(posedge aclk);
    endtask

    // capacity write only with the block idle, after all result words are drained
    task automatic write_capacity(input logic [bsdo_pkg::CAP_W-1:0] value);
        drain_results();
        repeat (3) @(posedge aclk);
        // setup cycle
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bsdo_pkg::ADDR_W'(bsdo_pkg::REG_CAPACITY) << 2;
        pwdata  <= bsdo_pkg::APB_DW'(value);
        @(posedge aclk);
        // access cycle, register taken at the edge with pready high
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_capacity(value);
    endtask

    // ready side: random stalls of mixed length
    initial begin
        int unsigned gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // main sequence
    initial begin
        logic [bsdo_pkg::CAP_W-1:0] phase_cap[8];
        int unsigned                push_pct;

        shadow  = new();
        no_idle = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset capacity: underflow on empty, value extremes, lifo order, clear
        send_word('{bsdo_pkg::CMD_POP,   32'h1234_5678});
        send_word('{bsdo_pkg::CMD_PEEK,  32'hFFFF_FFFF});
        send_word('{bsdo_pkg::CMD_PUSH,  32'h0000_0000});
        send_word('{bsdo_pkg::CMD_PUSH,  32'hFFFF_FFFF});
        send_word('{bsdo_pkg::CMD_PUSH,  32'hAAAA_AAAA});
        send_word('{bsdo_pkg::CMD_PUSH,  32'h5555_5555});
        send_word('{bsdo_pkg::CMD_PEEK,  32'h0});
        send_word('{bsdo_pkg::CMD_POP,   32'h0});
        send_word('{bsdo_pkg::CMD_POP,   32'h0});
        send_word('{bsdo_pkg::CMD_CLEAR, 32'hFFFF_FFFF});
        send_word('{bsdo_pkg::CMD_POP,   32'h0});

        // small capacity: third push drops the bottom word, then pop to empty
        write_capacity(5'd2);
        send_word('{bsdo_pkg::CMD_PUSH, 32'h0000_0001});
        send_word('{bsdo_pkg::CMD_PUSH, 32'h0000_0002});
        send_word('{bsdo_pkg::CMD_PUSH, 32'h0000_0003});
        send_word('{bsdo_pkg::CMD_POP,  32'h0});
        send_word('{bsdo_pkg::CMD_POP,  32'h0});
        send_word('{bsdo_pkg::CMD_POP,  32'h0});

        // zero capacity behaves as one
        write_capacity(5'd0);
        send_word('{bsdo_pkg::CMD_PUSH, 32'hDEAD_BEEF});
        send_word('{bsdo_pkg::CMD_PUSH, 32'hCAFE_F00D});
        send_word('{bsdo_pkg::CMD_PEEK, 32'h0});

        // random phases: extremes first, out-of-range values, then random
        phase_cap = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd8, 5'd16};
        phase_cap[5] = bsdo_pkg::CAP_W'($urandom_range(17, 31));
        phase_cap[6] = bsdo_pkg::CAP_W'($urandom_range(0, 31));
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_cap[p]);
            // one phase runs with no idling on either side
            no_idle = (p == 4);
            for (int i = 0; i < 200; i++) begin
                if (i % 50 == 0) push_pct = $urandom_range(30, 75);
                // sender holds off once until the result side has caught up
                if (p == 1 && i == 100) drain_results();
                send_word(random_word(push_pct));
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (5) @(posedge aclk);
        if (shadow.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
